>>> design/sspm_pkg.sv
`timescale 1ns / 1ps

package sspm_pkg;

   localparam int unsigned PCT_W = 7;
   localparam int unsigned TMR_W = 14;

   localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
   localparam logic [PCT_W-1:0] PCT_MIN  = 7'd0;
   localparam logic [PCT_W-1:0] SLAT_JOG = 7'd20;
   localparam logic [PCT_W-1:0] POS_JOG  = 7'd2;
   localparam logic [PCT_W-1:0] DRIFT    = 7'd10;

   localparam logic [TMR_W-1:0] TMR_MAX       = 14'd16383;
   localparam logic [TMR_W-1:0] STEP_LIM_SLOW = 14'd800;
   localparam logic [TMR_W-1:0] STEP_LIM_FAST = 14'd80;
   localparam logic [TMR_W-1:0] SLAT_LIM      = 14'd10;
   localparam logic [TMR_W-1:0] REF_LIM_SLOW  = 14'd10000;
   localparam logic [TMR_W-1:0] REF_LIM_FAST  = 14'd1000;

   localparam logic CSR_FAST_MODE = 1'b0;
   localparam logic CSR_HAS_SLAT  = 1'b1;

   typedef enum logic [2:0] {
      FUNC_TICK        = 3'd0,
      FUNC_CTRL_POS    = 3'd1,
      FUNC_CTRL_SLAT   = 3'd2,
      FUNC_MANUAL_POS  = 3'd3,
      FUNC_MANUAL_SLAT = 3'd4,
      FUNC_UP_DOWN     = 3'd5,
      FUNC_STEP_STOP   = 3'd6
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [PCT_W-1:0] percent;
      logic             direction;
   } req_word_type;

   typedef struct packed {
      logic [PCT_W-1:0] position_now;
      logic [PCT_W-1:0] slat_now;
      logic             is_moving;
      logic             send_position;
      logic             send_slat;
   } rsp_word_type;

   typedef struct packed {
      logic fast_mode;
      logic has_slat;
   } cfg_type;

   typedef struct packed {
      logic [PCT_W-1:0] pos_current;
      logic [PCT_W-1:0] slat_current;
      logic [PCT_W-1:0] pos_target;
      logic [PCT_W-1:0] slat_target;
      logic             motion_active;
      logic [TMR_W-1:0] ms_since_step;
      logic [TMR_W-1:0] ms_since_refresh;
      logic [PCT_W-1:0] pos_reported;
      logic [PCT_W-1:0] slat_reported;
   } state_type;

endpackage

>>> design/sspm_step.sv
`timescale 1ns / 1ps

module sspm_step
   import sspm_pkg::*;
(
   input  req_word_type word,
   input  state_type    state,
   input  cfg_type      cfg,
   output state_type    state_nxt,
   output rsp_word_type result
);

   typedef struct packed {
      state_type s;
      logic      tx_pos;
      logic      tx_slat;
   } work_type;

   function automatic work_type pub_pos(input work_type w);
      work_type r;
      r = w;
      r.s.pos_reported = r.s.pos_current;
      r.tx_pos = 1'b1;
      return r;
   endfunction

   function automatic work_type pub_slat(input work_type w, input logic has_slat);
      work_type r;
      r = w;
      if (has_slat) begin
         r.s.slat_reported = r.s.slat_current;
         r.tx_slat = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type go_active(input work_type w);
      work_type r;
      r = w;
      if (!r.s.motion_active) begin
         r.s.ms_since_refresh = '0;
      end
      r.s.motion_active = 1'b1;
      r.s.ms_since_step = '0;
      return r;
   endfunction

   function automatic work_type go_idle(input work_type w, input logic has_slat);
      work_type r;
      r = w;
      r.s.motion_active = 1'b0;
      r.s.ms_since_step = '0;
      r.s.ms_since_refresh = '0;
      if (r.s.pos_reported != r.s.pos_current) begin
         r = pub_pos(r);
      end
      if (r.s.slat_reported != r.s.slat_current) begin
         r = pub_slat(r, has_slat);
      end
      return r;
   endfunction

   function automatic work_type evaluate(input work_type w, input logic has_slat);
      work_type r;
      if (w.s.pos_target != w.s.pos_current || w.s.slat_target != w.s.slat_current) begin
         r = go_active(w);
      end else begin
         r = go_idle(w, has_slat);
      end
      return r;
   endfunction

   logic [PCT_W-1:0] pct;
   logic [PCT_W-1:0] new_pos;
   logic [PCT_W-1:0] drift;
   logic [TMR_W-1:0] step_lim;
   logic [TMR_W-1:0] ref_lim;
   work_type         w;

   assign pct      = (word.percent > PCT_MAX) ? PCT_MAX : word.percent;
   assign step_lim = cfg.fast_mode ? STEP_LIM_FAST : STEP_LIM_SLOW;
   assign ref_lim  = cfg.fast_mode ? REF_LIM_FAST : REF_LIM_SLOW;

   always_comb begin
      w.s = state;
      w.tx_pos = 1'b0;
      w.tx_slat = 1'b0;
      new_pos = state.pos_target;
      drift = '0;
      case (word.func)
         FUNC_TICK: begin
            if (w.s.motion_active) begin
               if (w.s.ms_since_step != TMR_MAX) begin
                  w.s.ms_since_step = w.s.ms_since_step + 14'd1;
               end
               if (w.s.ms_since_refresh != TMR_MAX) begin
                  w.s.ms_since_refresh = w.s.ms_since_refresh + 14'd1;
               end
               if (w.s.pos_target != w.s.pos_current) begin
                  if (w.s.ms_since_step > step_lim) begin
                     if (w.s.pos_target > w.s.pos_current) begin
                        w.s.pos_current = w.s.pos_current + 7'd1;
                        w.s.slat_current = PCT_MAX;
                     end else begin
                        w.s.pos_current = w.s.pos_current - 7'd1;
                        w.s.slat_current = PCT_MIN;
                     end
                     if (w.s.pos_target != w.s.pos_current) begin
                        drift = (w.s.pos_reported > w.s.pos_current) ?
                                w.s.pos_reported - w.s.pos_current :
                                w.s.pos_current - w.s.pos_reported;
                        if (drift >= DRIFT) begin
                           w = pub_pos(w);
                        end
                        w = go_active(w);
                     end else begin
                        w = pub_pos(w);
                        w = pub_slat(w, cfg.has_slat);
                        if (w.s.slat_target != w.s.slat_current) begin
                           w = go_active(w);
                        end else begin
                           w = go_idle(w, cfg.has_slat);
                        end
                     end
                  end
               end else if (w.s.slat_target != w.s.slat_current) begin
                  if (w.s.ms_since_step > SLAT_LIM) begin
                     if (w.s.slat_target > w.s.slat_current) begin
                        w.s.slat_current = w.s.slat_current + 7'd1;
                     end else begin
                        w.s.slat_current = w.s.slat_current - 7'd1;
                     end
                     if (w.s.slat_target != w.s.slat_current) begin
                        w = go_active(w);
                     end else begin
                        w = go_idle(w, cfg.has_slat);
                        w = pub_slat(w, cfg.has_slat);
                     end
                  end
               end
               if (w.s.motion_active && w.s.ms_since_refresh > ref_lim) begin
                  if (w.s.pos_reported != w.s.pos_current) begin
                     w = pub_pos(w);
                  end
                  if (w.s.slat_reported != w.s.slat_current) begin
                     w = pub_slat(w, cfg.has_slat);
                  end
                  w.s.ms_since_refresh = '0;
               end
            end
         end
         FUNC_CTRL_POS: begin
            new_pos = pct;
         end
         FUNC_CTRL_SLAT, FUNC_MANUAL_SLAT: begin
            w.s.slat_target = pct;
         end
         FUNC_MANUAL_POS: begin
            new_pos = pct;
            if (pct < w.s.pos_target) begin
               w.s.slat_target = PCT_MIN;
            end else if (pct > w.s.pos_target) begin
               w.s.slat_target = PCT_MAX;
            end
         end
         FUNC_UP_DOWN: begin
            new_pos = word.direction ? PCT_MAX : PCT_MIN;
            w.s.slat_target = new_pos;
         end
         FUNC_STEP_STOP: begin
            if (w.s.pos_target != w.s.pos_current || w.s.slat_target != w.s.slat_current) begin
               new_pos = w.s.pos_current;
               w.s.slat_target = w.s.slat_current;
            end else if (word.direction) begin
               if (w.s.slat_target != PCT_MIN) begin
                  w.s.slat_target = (w.s.slat_target > SLAT_JOG) ?
                                    w.s.slat_target - SLAT_JOG : PCT_MIN;
               end else if (new_pos != PCT_MIN) begin
                  new_pos = (new_pos > POS_JOG) ? new_pos - POS_JOG : PCT_MIN;
               end
            end else begin
               if (w.s.slat_target != PCT_MAX) begin
                  w.s.slat_target = (w.s.slat_target + SLAT_JOG < PCT_MAX) ?
                                    w.s.slat_target + SLAT_JOG : PCT_MAX;
               end else if (new_pos != PCT_MAX) begin
                  new_pos = (new_pos + POS_JOG < PCT_MAX) ? new_pos + POS_JOG : PCT_MAX;
               end
            end
            w.s.pos_target = new_pos;
            w = evaluate(w, cfg.has_slat);
         end
         default: begin
         end
      endcase
      if ((word.func == FUNC_CTRL_POS || word.func == FUNC_CTRL_SLAT ||
           word.func == FUNC_MANUAL_POS || word.func == FUNC_MANUAL_SLAT ||
           word.func == FUNC_UP_DOWN) && new_pos != w.s.pos_target) begin
         w.s.pos_target = new_pos;
         w = evaluate(w, cfg.has_slat);
      end
   end

   assign state_nxt = w.s;
   assign result.position_now  = w.s.pos_current;
   assign result.slat_now      = w.s.slat_current;
   assign result.is_moving     = w.s.motion_active &&
                                 (w.s.pos_target != w.s.pos_current ||
                                  w.s.slat_target != w.s.slat_current);
   assign result.send_position = w.tx_pos;
   assign result.send_slat     = w.tx_slat;

endmodule

>>> design/shutter_slat_position_model.sv
`timescale 1ns / 1ps

// channel  ports                                      direction
// req      req_valid, req_stall, req_word              command or tick word in
// rsp      rsp_valid, rsp_stall, rsp_word              one status word out per req word
// csr      csr_valid, csr_ready, csr_index, csr_data   register write in
//
// one word per cycle while req_stall is low; a taken word passes through the input register,
// then the result register around one pass of the step logic
// synchronous reset clears the blind state, the timers and the valid flags
// csr_ready is always high
// req_stall rises only when both registers hold words and rsp_stall is high

module shutter_slat_position_model
   import sspm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic         csr_data
);

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_word_type s1_word_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   state_type    state_ff;
   state_type    state_in;
   cfg_type      cfg_ff;
   rsp_word_type result;
   logic         advance;
   logic         take;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign take         = req_valid && !req_stall;
   assign s1_valid_in  = take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word     = rsp_word_ff;

   sspm_step u_step (
      .word      (s1_word_ff),
      .state     (state_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
         cfg_ff.fast_mode <= 1'b0;
         cfg_ff.has_slat <= 1'b1;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FAST_MODE: cfg_ff.fast_mode <= csr_data;
               CSR_HAS_SLAT:  cfg_ff.has_slat <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

endmodule

>>> bench/blind_status_checker.sv
`timescale 1ns / 1ps

module blind_status_checker
   import sspm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic         csr_index,
   input  logic         csr_data,
   output int           fail_count,
   output int           words_pending
);

   logic [PCT_W-1:0] cur_pos, cur_slat, aim_pos, aim_slat, shown_pos, shown_slat;
   logic [TMR_W-1:0] step_ms, refresh_ms;
   logic             active, fast_q, has_slat_q, sent_pos, sent_slat;
   rsp_word_type     status_due[$];
   rsp_word_type     due;
   int               fails;

   function automatic void publish_position();
      shown_pos = cur_pos;
      sent_pos = 1'b1;
   endfunction

   function automatic void publish_slat();
      if (has_slat_q) begin
         shown_slat = cur_slat;
         sent_slat = 1'b1;
      end
   endfunction

   function automatic void start_motion();
      if (!active) refresh_ms = '0;
      active = 1'b1;
      step_ms = '0;
   endfunction

   function automatic void halt_motion();
      active = 1'b0;
      step_ms = '0;
      refresh_ms = '0;
      if (shown_pos != cur_pos) publish_position();
      if (shown_slat != cur_slat) publish_slat();
   endfunction

   function automatic void settle_motion();
      if (aim_pos != cur_pos || aim_slat != cur_slat) start_motion();
      else halt_motion();
   endfunction

   function automatic void run_millisecond();
      logic [TMR_W-1:0] step_lim, ref_lim;
      logic [PCT_W-1:0] gap;
      if (active) begin
         step_lim = fast_q ? STEP_LIM_FAST : STEP_LIM_SLOW;
         ref_lim = fast_q ? REF_LIM_FAST : REF_LIM_SLOW;
         if (step_ms != TMR_MAX) step_ms++;
         if (refresh_ms != TMR_MAX) refresh_ms++;
         if (aim_pos != cur_pos) begin
            if (step_ms > step_lim) begin
               if (aim_pos > cur_pos) begin
                  cur_pos++;
                  cur_slat = PCT_MAX;
               end else begin
                  cur_pos--;
                  cur_slat = PCT_MIN;
               end
               if (aim_pos != cur_pos) begin
                  gap = (shown_pos > cur_pos) ? shown_pos - cur_pos : cur_pos - shown_pos;
                  if (gap >= DRIFT) publish_position();
                  start_motion();
               end else begin
                  publish_position();
                  publish_slat();
                  if (aim_slat != cur_slat) start_motion();
                  else halt_motion();
               end
            end
         end else if (aim_slat != cur_slat) begin
            if (step_ms > SLAT_LIM) begin
               if (aim_slat > cur_slat) cur_slat++;
               else cur_slat--;
               if (aim_slat != cur_slat) begin
                  start_motion();
               end else begin
                  halt_motion();
                  publish_slat();
               end
            end
         end
         if (active && refresh_ms > ref_lim) begin
            if (shown_pos != cur_pos) publish_position();
            if (shown_slat != cur_slat) publish_slat();
            refresh_ms = '0;
         end
      end
   endfunction

   function automatic rsp_word_type predict_status(input req_word_type w);
      logic [PCT_W-1:0] pct, next_pos;
      rsp_word_type     s;
      pct = (w.percent > PCT_MAX) ? PCT_MAX : w.percent;
      next_pos = aim_pos;
      sent_pos = 1'b0;
      sent_slat = 1'b0;
      case (w.func)
         FUNC_TICK: run_millisecond();
         FUNC_CTRL_POS: next_pos = pct;
         FUNC_CTRL_SLAT, FUNC_MANUAL_SLAT: aim_slat = pct;
         FUNC_MANUAL_POS: begin
            next_pos = pct;
            if (next_pos < aim_pos) aim_slat = PCT_MIN;
            else if (next_pos > aim_pos) aim_slat = PCT_MAX;
         end
         FUNC_UP_DOWN: begin
            next_pos = w.direction ? PCT_MAX : PCT_MIN;
            aim_slat = next_pos;
         end
         FUNC_STEP_STOP: begin
            if (aim_pos != cur_pos || aim_slat != cur_slat) begin
               next_pos = cur_pos;
               aim_slat = cur_slat;
            end else if (w.direction) begin
               if (aim_slat != PCT_MIN)
                  aim_slat = (aim_slat > SLAT_JOG) ? aim_slat - SLAT_JOG : PCT_MIN;
               else if (next_pos != PCT_MIN)
                  next_pos = (next_pos > POS_JOG) ? next_pos - POS_JOG : PCT_MIN;
            end else begin
               if (aim_slat != PCT_MAX)
                  aim_slat = (aim_slat + SLAT_JOG < PCT_MAX) ? aim_slat + SLAT_JOG : PCT_MAX;
               else if (next_pos != PCT_MAX)
                  next_pos = (next_pos + POS_JOG < PCT_MAX) ? next_pos + POS_JOG : PCT_MAX;
            end
            aim_pos = next_pos;
            settle_motion();
         end
         default: ;
      endcase
      if (w.func != FUNC_TICK && w.func != FUNC_STEP_STOP && next_pos != aim_pos) begin
         aim_pos = next_pos;
         settle_motion();
      end
      s.position_now = cur_pos;
      s.slat_now = cur_slat;
      s.is_moving = active && (aim_pos != cur_pos || aim_slat != cur_slat);
      s.send_position = sent_pos;
      s.send_slat = sent_slat;
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cur_pos = '0;
         cur_slat = '0;
         aim_pos = '0;
         aim_slat = '0;
         shown_pos = '0;
         shown_slat = '0;
         step_ms = '0;
         refresh_ms = '0;
         active = 1'b0;
         fast_q = 1'b0;
         has_slat_q = 1'b1;
         fails = 0;
         status_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HAS_SLAT) has_slat_q = csr_data;
            else fast_q = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (status_due.size() == 0) begin
               fails++;
               $display("%0t: status word with none expected, got pos %0d slat %0d moving %b send %b%b",
                        $time, rsp_word.position_now, rsp_word.slat_now, rsp_word.is_moving,
                        rsp_word.send_position, rsp_word.send_slat);
            end else begin
               due = status_due.pop_front();
               if (rsp_word !== due) begin
                  fails++;
                  $display("%0t: status mismatch, expected pos %0d slat %0d moving %b send %b%b",
                           $time, due.position_now, due.slat_now, due.is_moving,
                           due.send_position, due.send_slat);
                  $display("%0t:                 actual   pos %0d slat %0d moving %b send %b%b",
                           $time, rsp_word.position_now, rsp_word.slat_now, rsp_word.is_moving,
                           rsp_word.send_position, rsp_word.send_slat);
               end
            end
         end
         if (req_valid && !req_stall) status_due.push_back(predict_status(req_word));
      end
      fail_count <= fails;
      words_pending <= status_due.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sspm_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_WORDS    = 60;

   logic         clock, reset;
   logic         req_valid, req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_valid, csr_ready, csr_index, csr_data;
   int           fail_count, words_pending;
   int           send_idle_pct, recv_stall_pct;
   int           words_sent;
   int           quiet_cycles = 0;

   shutter_slat_position_model dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   blind_status_checker status_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type make_word(input func_type f, input logic [PCT_W-1:0] pct,
                                              input logic dir);
      req_word_type w;
      w.func = f;
      w.percent = pct;
      w.direction = dir;
      return w;
   endfunction

   function automatic logic [PCT_W-1:0] pick_percent();
      case ($urandom_range(0, 3))
         0: return PCT_W'($urandom_range(0, 127));
         1: return PCT_W'($urandom_range(0, 4));
         2: return PCT_W'($urandom_range(96, 100));
         default: return PCT_W'($urandom_range(0, 100));
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input req_word_type w);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_ticks(input int count);
      repeat (count)
         send_word(make_word(FUNC_TICK, PCT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (words_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_config(input logic fast, input logic slat);
      for (int i = 0; i < 2; i++) begin
         csr_valid <= 1'b1;
         csr_index <= (i == 0) ? CSR_FAST_MODE : CSR_HAS_SLAT;
         csr_data <= (i == 0) ? fast : slat;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_episode();
      int pick;
      int ticks;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // freeze if moving, otherwise jog
         send_word(make_word(FUNC_STEP_STOP, pick_percent(), 1'($urandom_range(0, 1))));
         send_word(make_word(FUNC_STEP_STOP, pick_percent(), 1'($urandom_range(0, 1))));
      end else if (pick < 40) begin
         send_word(make_word(FUNC_UP_DOWN, pick_percent(), 1'($urandom_range(0, 1))));
      end else if (pick < 50) begin
         send_word(make_word(func_type'(3'($urandom_range(0, 7))),
                             PCT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
      end else begin
         send_word(make_word(func_type'(3'($urandom_range(1, 4))), pick_percent(),
                             1'($urandom_range(0, 1))));
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) ticks = $urandom_range(0, 15);
      else if (pick < 9) ticks = $urandom_range(16, 120);
      else ticks = $urandom_range(121, 260);
      send_ticks(ticks);
   endtask

   initial begin
      int goal;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FAST_MODE;
      csr_data = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      words_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(make_word(FUNC_TICK, PCT_MIN, 1'b0));
      send_word(make_word(func_type'(3'd7), 7'd127, 1'b1));
      send_word(make_word(FUNC_CTRL_SLAT, 7'd127, 1'b0));
      send_word(make_word(FUNC_STEP_STOP, PCT_MIN, 1'b0));
      send_word(make_word(FUNC_STEP_STOP, PCT_MAX, 1'b0));
      send_ticks(11);
      send_word(make_word(FUNC_STEP_STOP, PCT_MIN, 1'b1));
      send_word(make_word(FUNC_MANUAL_POS, 7'd127, 1'b0));
      send_word(make_word(FUNC_MANUAL_POS, PCT_MIN, 1'b1));
      send_word(make_word(FUNC_UP_DOWN, PCT_MIN, 1'b1));
      send_word(make_word(FUNC_UP_DOWN, PCT_MAX, 1'b0));
      send_word(make_word(FUNC_MANUAL_SLAT, PCT_MIN, 1'b0));
      send_word(make_word(FUNC_CTRL_POS, 7'd1, 1'b1));
      send_word(make_word(FUNC_CTRL_POS, PCT_MIN, 1'b0));
      send_word(make_word(FUNC_STEP_STOP, PCT_MIN, 1'b1));

      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: set_config(1'b1, 1'b1);
            1: set_config(1'b0, 1'b0);
            2: set_config(1'b1, 1'b0);
            default: set_config(1'b0, 1'b1);
         endcase
         send_idle_pct = (p == 0) ? 30 : (p == 1) ? 80 : 0;
         recv_stall_pct = (p == 0) ? 80 : (p == 1) ? 30 : 0;
         if (p == 0) begin
            // long run at fast rate: drift report and refresh
            send_word(make_word(FUNC_UP_DOWN, PCT_MAX, 1'b1));
            send_ticks(1010);
         end
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) run_episode();
      end

      drain();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
